FILE: rtl/vital_sign_spike_filter_alarm_assert.svh
// Assertion macros used by the vital sign filter RTL.
// Relies on clk and arst_n being present in the module that uses them.
`ifndef VITAL_SIGN_SPIKE_FILTER_ALARM_ASSERT_SVH
`define VITAL_SIGN_SPIKE_FILTER_ALARM_ASSERT_SVH
`ifndef ASSERT_OFF
`define VSSFA_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("vssfa assertion failed");
`define VSSFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vssfa assertion failed");
`else
`define VSSFA_ASSERT_ALWAYS(lbl, cond)
`define VSSFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/vssfa_pkg.sv
// Shared types and constants of the vital sign spike filter and alarm.
// No dependencies.
`timescale 1ns / 1ps

package vssfa_pkg;

	localparam int SAMPLE_W = 12;
	localparam int OXY_W    = 8;
	localparam int STATUS_W = 2;

	localparam logic [SAMPLE_W-1:0] LAST_RESET  = 12'd4095;
	localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 12'd4095;
	localparam logic [OXY_W-1:0]    OXY_RESET   = 8'd90;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK           = 2'd0,
		STATUS_ALERT        = 2'd1,
		STATUS_DISCONNECTED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_GAS_STEP   = 3'd0,
		REG_TEMP_STEP  = 3'd1,
		REG_GAS_ALARM  = 3'd2,
		REG_TEMP_ALARM = 3'd3,
		REG_OXY_ALARM  = 3'd4
	} reg_idx_t;

	// Per-channel result of one beat: average after the update, block completed
	typedef struct packed {
		logic [SAMPLE_W-1:0] avg;
		logic                done;
	} chan_res_t;

endpackage

FILE: rtl/vital_sign_spike_filter_alarm.sv
// Top level of the vital sign spike filter and alarm: stream ports, APB registers.
// Depends on vssfa_pkg and vssfa_chan.
`timescale 1ns / 1ps

// Usage:
// Each input beat on the s_ side carries one converter sample, an oximeter
// reading and the panic flag. Samples alternate gas, temperature, gas, ...
// starting with gas after reset. Every input beat yields exactly one output
// beat on the m_ side with the status, both stored block averages, the held
// oxygen value and a flag marking a completed block average.
// An accepted beat is held in the input register and then moves to the
// output register, which raises m_tvalid. Throughput: one beat per cycle
// while the receiver takes beats; the input register feeds a single pass of
// spike rejection, block sum and reciprocal multiply, and the channel state is
// rewritten in the same edge that loads the output register.
// Reset clears the channel pointer, sums, counts and averages, sets the last
// values to full scale and loads the register reset values.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and s_tready drops until the output is taken.
// Registers (APB, byte address 4*i): gas step limit, temperature step limit,
// gas alarm level, temperature alarm level, oxygen alarm level. Write only
// while the block is idle.

module vital_sign_spike_filter_alarm
	import vssfa_pkg::*;
#(
	parameter int BLOCK_LAST_INDEX = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sample[11:0], oxygen_reading[19:12], panic_active[20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // status[1:0], gas_average[13:2], temp_average[25:14],
	                               // oxygen_value[33:26], average_done[34]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [SAMPLE_W-1:0] gas_step_q, temp_step_q, gas_alarm_q, temp_alarm_q;
	logic [OXY_W-1:0]    oxy_alarm_q;
	logic [2:0]          reg_idx;
	logic                reg_wr;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [OXY_W-1:0]    oxy_s1;
	logic                panic_s1;

	logic                ptr_q;
	logic [OXY_W-1:0]    oxy_hold_q;
	logic                m_valid_q;
	logic [39:0]         m_data_q;

	logic                out_free;
	logic                advance;
	chan_res_t           gas_res, temp_res;
	logic                oxy_ok;
	status_t             status;
	logic [OXY_W-1:0]    oxy_next;

	// Configuration
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_step_q   <= LIMIT_RESET;
			temp_step_q  <= LIMIT_RESET;
			gas_alarm_q  <= LIMIT_RESET;
			temp_alarm_q <= LIMIT_RESET;
			oxy_alarm_q  <= OXY_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_GAS_STEP:   gas_step_q   <= pwdata[SAMPLE_W-1:0];
				REG_TEMP_STEP:  temp_step_q  <= pwdata[SAMPLE_W-1:0];
				REG_GAS_ALARM:  gas_alarm_q  <= pwdata[SAMPLE_W-1:0];
				REG_TEMP_ALARM: temp_alarm_q <= pwdata[SAMPLE_W-1:0];
				REG_OXY_ALARM:  oxy_alarm_q  <= pwdata[OXY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAS_STEP:   prdata = {20'd0, gas_step_q};
			REG_TEMP_STEP:  prdata = {20'd0, temp_step_q};
			REG_GAS_ALARM:  prdata = {20'd0, gas_alarm_q};
			REG_TEMP_ALARM: prdata = {20'd0, temp_alarm_q};
			REG_OXY_ALARM:  prdata = {24'd0, oxy_alarm_q};
			default:        prdata = '0;
		endcase
	end

	// Handshake: input register advances whenever the output register frees up
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[11:0];
			oxy_s1    <= s_tdata[19:12];
			panic_s1  <= s_tdata[20];
		end
	end

	vssfa_chan #(
		.BLOCK_LAST_INDEX(BLOCK_LAST_INDEX)
	) u_gas (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (advance && !ptr_q),
		.sample    (sample_s1),
		.step_limit(gas_step_q),
		.res       (gas_res)
	);

	vssfa_chan #(
		.BLOCK_LAST_INDEX(BLOCK_LAST_INDEX)
	) u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (advance && ptr_q),
		.sample    (sample_s1),
		.step_limit(temp_step_q),
		.res       (temp_res)
	);

	always_comb begin
		oxy_ok   = (oxy_s1 != '0) && (oxy_s1 >= oxy_alarm_q);
		oxy_next = oxy_ok ? oxy_s1 : oxy_hold_q;
		if (oxy_s1 == '0 && !panic_s1) begin
			status = STATUS_DISCONNECTED;
		end else if (panic_s1 || (oxy_s1 != '0 && oxy_s1 < oxy_alarm_q)
				|| gas_res.avg > gas_alarm_q || temp_res.avg > temp_alarm_q) begin
			status = STATUS_ALERT;
		end else begin
			status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= 1'b0;
			oxy_hold_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				ptr_q      <= !ptr_q;
				oxy_hold_q <= oxy_next;
				m_valid_q  <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {5'd0, (gas_res.done || temp_res.done), oxy_next,
				temp_res.avg, gas_res.avg, status};
		end
	end

endmodule

FILE: rtl/vssfa_chan.sv
// One sensor channel: spike rejection, block sum and block average.
// Depends on vssfa_pkg and vital_sign_spike_filter_alarm_assert.svh.
`timescale 1ns / 1ps
`include "vital_sign_spike_filter_alarm_assert.svh"

module vssfa_chan
	import vssfa_pkg::*;
#(
	parameter int BLOCK_LAST_INDEX = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                feed,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [SAMPLE_W-1:0] step_limit,
	output chan_res_t           res
);

	localparam int BLOCK_LEN = BLOCK_LAST_INDEX + 1;
	localparam int CNT_W     = $clog2(BLOCK_LAST_INDEX + 2);
	localparam int SUM_W     = SAMPLE_W + $clog2(BLOCK_LEN);
	localparam int DIV_SHIFT = SUM_W + $clog2(BLOCK_LEN);
	localparam int MAG_W     = SUM_W + 1;
	localparam int PROD_W    = SUM_W + MAG_W;
	// Round-up reciprocal: exact truncating quotient for every sum below 2**SUM_W
	localparam longint unsigned MAGIC_WIDE = (64'd1 << DIV_SHIFT) / BLOCK_LEN + 64'd1;
	localparam logic [MAG_W-1:0] DIV_MAGIC = MAGIC_WIDE[MAG_W-1:0];
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(BLOCK_LAST_INDEX);

	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] last_q;
	logic [SAMPLE_W-1:0] avg_q;

	logic [SAMPLE_W:0]   ceiling;
	logic [SAMPLE_W-1:0] kept;
	logic                nonzero;
	logic [SUM_W-1:0]    sum_add;
	logic [CNT_W-1:0]    cnt_add;
	logic                complete;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   quot_full;
	logic [SAMPLE_W-1:0] quot;

	always_comb begin
		ceiling   = {1'b0, last_q} + {1'b0, step_limit};
		// Replace a spike by the last accepted value, or by the block average after a block completes
		kept      = ({1'b0, sample} > ceiling) ? last_q : sample;
		nonzero   = (kept != '0);
		sum_add   = sum_q + (nonzero ? SUM_W'(kept) : '0);
		cnt_add   = cnt_q + CNT_W'(nonzero);
		complete  = (cnt_add > CNT_LAST);
		prod      = {{MAG_W{1'b0}}, sum_add} * {{SUM_W{1'b0}}, DIV_MAGIC};
		quot_full = prod >> DIV_SHIFT;
		quot      = quot_full[SAMPLE_W-1:0];
		res.done  = feed && complete;
		res.avg   = (feed && complete) ? quot : avg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			last_q <= LAST_RESET;
			avg_q  <= '0;
		end else if (feed) begin
			if (complete) begin
				avg_q  <= quot;
				last_q <= quot;
				sum_q  <= '0;
				cnt_q  <= '0;
			end else begin
				sum_q <= sum_add;
				cnt_q <= cnt_add;
				if (nonzero) begin
					last_q <= kept;
				end
			end
		end
	end

	`VSSFA_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_LAST)
	`VSSFA_ASSERT_NEXT(a_block_clear, res.done, (cnt_q == '0) && (sum_q == '0) && (last_q == avg_q))
	`VSSFA_ASSERT_NEXT(a_avg_hold, !feed, $stable(avg_q) && $stable(sum_q))

endmodule

FILE: tb/tb_vital_sign_spike_filter_alarm.sv
// Self-checking bench for the vital sign spike filter and alarm: stream beats in,
// status and block averages out, registers written over APB between phases.
// Depends on vssfa_pkg and the vital_sign_spike_filter_alarm RTL.
`timescale 1ns / 1ps

module tb_vital_sign_spike_filter_alarm;
	import vssfa_pkg::*;

	localparam int BLOCK_LAST  = 7;
	localparam int BLOCK_LEN   = BLOCK_LAST + 1;
	localparam int GAS         = 0;
	localparam int TEMP        = 1;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_BEATS = 241;
	localparam int MAX_REPORTS = 40;

	typedef struct {
		status_t             status;
		logic [SAMPLE_W-1:0] gas_avg;
		logic [SAMPLE_W-1:0] temp_avg;
		logic [OXY_W-1:0]    oxy;
		logic                done;
	} vitals_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // sample[11:0], oxygen_reading[19:12], panic_active[20]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // status[1:0], gas_average[13:2], temp_average[25:14],
	                         // oxygen_value[33:26], average_done[34]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	vital_sign_spike_filter_alarm #(
		.BLOCK_LAST_INDEX(BLOCK_LAST)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [23:0] sample_beat_q[$];
	vitals_t     vitals_due_q[$];

	// Mirror of the block's registers and channel state, index GAS or TEMP
	int step_limit[2];
	int alarm_level[2];
	int oxy_alarm;
	int ch_sum[2];
	int ch_cnt[2];
	int ch_last[2];
	int ch_avg[2];
	int chan_sel;
	int oxy_hold;

	int fail_count    = 0;
	int beats_in      = 0;
	int blocks_done   = 0;
	int spikes_cut    = 0;
	int zeros_skipped = 0;
	int settings_used = 0;
	int status_seen[3];

	bit in_taken   = 1'b0;
	bit burst_mode = 1'b0;
	bit sink_hold  = 1'b0;
	int src_gap    = 0;
	int sink_gap   = 0;
	int gen_ptr    = GAS;
	int gen_base[2];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d beats still expected", vitals_due_q.size());
		$display("tb_vital_sign_spike_filter_alarm NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int clamp12(int v);
		if (v < 0)
			return 0;
		if (v > 4095)
			return 4095;
		return v;
	endfunction

	// Advance the mirrored state by one accepted beat and return its result
	function automatic vitals_t predict_vitals(logic [23:0] beat);
		vitals_t v;
		int      c;
		int      s;
		int      oxy;
		bit      panic;
		c     = chan_sel;
		s     = beat[11:0];
		oxy   = beat[19:12];
		panic = beat[20];
		v.done = 1'b0;
		if (s > ch_last[c] + step_limit[c]) begin
			s = ch_last[c];
			spikes_cut++;
		end
		if (s != 0) begin
			ch_sum[c] += s;
			ch_last[c] = s;
			ch_cnt[c]++;
		end else begin
			zeros_skipped++;
		end
		if (ch_cnt[c] > BLOCK_LAST) begin
			ch_avg[c]  = (ch_sum[c] / BLOCK_LEN) & 'hFFF;
			ch_last[c] = ch_avg[c];
			ch_sum[c]  = 0;
			ch_cnt[c]  = 0;
			v.done     = 1'b1;
			blocks_done++;
		end
		chan_sel ^= 1;
		if (oxy != 0 && oxy >= oxy_alarm)
			oxy_hold = oxy;
		if (oxy == 0 && !panic)
			v.status = STATUS_DISCONNECTED;
		else if (panic || (oxy != 0 && oxy < oxy_alarm) ||
		         ch_avg[GAS] > alarm_level[GAS] || ch_avg[TEMP] > alarm_level[TEMP])
			v.status = STATUS_ALERT;
		else
			v.status = STATUS_OK;
		status_seen[int'(v.status)]++;
		v.gas_avg  = SAMPLE_W'(ch_avg[GAS]);
		v.temp_avg = SAMPLE_W'(ch_avg[TEMP]);
		v.oxy      = OXY_W'(oxy_hold);
		return v;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
	endtask

	// Sample the stream handshakes at the rising edge
	always @(posedge clk) begin : monitor
		vitals_t     want;
		logic [39:0] got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				vitals_due_q.push_back(predict_vitals(s_tdata));
				in_taken = 1'b1;
				beats_in++;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (vitals_due_q.size() == 0) begin
					report_mismatch("beat with nothing expected", got, 0);
				end else begin
					want = vitals_due_q.pop_front();
					if (got[1:0] !== want.status)
						report_mismatch("status", got[1:0], want.status);
					if (got[13:2] !== want.gas_avg)
						report_mismatch("gas_average", got[13:2], want.gas_avg);
					if (got[25:14] !== want.temp_avg)
						report_mismatch("temp_average", got[25:14], want.temp_avg);
					if (got[33:26] !== want.oxy)
						report_mismatch("oxygen_value", got[33:26], want.oxy);
					if (got[34] !== want.done)
						report_mismatch("average_done", got[34], want.done);
				end
			end
		end
	end

	always @(negedge clk) begin : feeder
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			in_taken = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (sample_beat_q.size() != 0) begin
				s_tdata  <= sample_beat_q.pop_front();
				s_tvalid <= 1'b1;
				src_gap = burst_mode ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : sink
		if (!arst_n || sink_hold) begin
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!burst_mode && $urandom_range(0, 3) == 0)
				sink_gap = pick_gap();
		end
	end

	task automatic add_beat(int s, int oxy, bit panic);
		logic [11:0] s12;
		logic [7:0]  o8;
		s12 = 12'(s);
		o8  = 8'(oxy);
		sample_beat_q.push_back({3'b000, panic, o8, s12});
		gen_ptr ^= 1;
	endtask

	// Mostly smooth readings around a per-channel level, with spikes, zeros and noise
	task automatic queue_vitals(int n);
		int i;
		int c;
		int r;
		int s;
		int oxy;
		bit panic;
		for (i = 0; i < n; i++) begin
			c = gen_ptr;
			if ($urandom_range(0, 15) == 0)
				gen_base[c] = clamp12(gen_base[c] + int'($urandom_range(0, 200)) - 100);
			r = $urandom_range(0, 99);
			if (r < 68)
				s = gen_base[c] + int'($urandom_range(0, 80)) - 40;
			else if (r < 80)
				s = gen_base[c] + step_limit[c] + int'($urandom_range(1, 400));
			else if (r < 88)
				s = 0;
			else
				s = $urandom_range(0, 4095);
			r = $urandom_range(0, 99);
			if (r < 10)
				oxy = 0;
			else if (r < 25 && oxy_alarm > 1)
				oxy = $urandom_range(1, oxy_alarm - 1);
			else if (r < 35)
				oxy = 255;
			else
				oxy = $urandom_range(oxy_alarm, 255);
			panic = ($urandom_range(0, 7) == 0);
			add_beat(clamp12(s), oxy, panic);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, int val, bit junk);
		logic [31:0] word;
		word = val;
		// garbage above the register width must be dropped
		if (junk)
			word = word | ($urandom() &
				((idx == REG_OXY_ALARM) ? 32'hFFFF_FF00 : 32'hFFFF_F000));
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GAS_STEP:   step_limit[GAS]   = word[11:0];
			REG_TEMP_STEP:  step_limit[TEMP]  = word[11:0];
			REG_GAS_ALARM:  alarm_level[GAS]  = word[11:0];
			REG_TEMP_ALARM: alarm_level[TEMP] = word[11:0];
			REG_OXY_ALARM:  oxy_alarm         = word[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int g_step, int t_step, int g_alarm, int t_alarm, int oxy,
	                          bit junk);
		write_reg(REG_GAS_STEP, g_step, junk);
		write_reg(REG_TEMP_STEP, t_step, junk);
		write_reg(REG_GAS_ALARM, g_alarm, junk);
		write_reg(REG_TEMP_ALARM, t_alarm, junk);
		write_reg(REG_OXY_ALARM, oxy, junk);
		settings_used++;
	endtask

	// Every beat yields one result, so an empty expectation store means idle
	task automatic drain_pipeline();
		while (sample_beat_q.size() != 0 || s_tvalid || vitals_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : main
		int p;
		int k;
		int lim[2];
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		step_limit[GAS]   = LIMIT_RESET;
		step_limit[TEMP]  = LIMIT_RESET;
		alarm_level[GAS]  = 4095;
		alarm_level[TEMP] = 4095;
		oxy_alarm         = OXY_RESET;
		for (k = 0; k < 2; k++) begin
			ch_sum[k]  = 0;
			ch_cnt[k]  = 0;
			ch_last[k] = LAST_RESET;
			ch_avg[k]  = 0;
		end
		chan_sel = GAS;
		oxy_hold = 0;
		for (k = 0; k < 3; k++)
			status_seen[k] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero skip, disconnect, panic, oxygen at and under the level
		add_beat(0, 0, 1'b0);
		add_beat(4095, 0, 1'b1);
		add_beat(4095, 89, 1'b0);
		add_beat(1, 90, 1'b0);
		add_beat(4095, 255, 1'b1);
		// complete a full-scale gas block and a temperature block
		for (k = 0; k < 13; k++) begin
			if (gen_ptr == GAS)
				add_beat(4095, 100 + k, 1'b0);
			else
				add_beat(100, 95, 1'b0);
		end
		drain_pipeline();

		// Gas average now above its level; temperature last value is 100
		set_config(0, 10, 4094, 4095, 255, 1'b0);
		add_beat(4095, 254, 1'b0);
		add_beat(111, 255, 1'b0);
		add_beat(0, 255, 1'b0);
		add_beat(110, 200, 1'b0);
		add_beat(4095, 0, 1'b1);
		add_beat(4095, 255, 1'b0);
		drain_pipeline();

		for (p = 0; p < NUM_PHASES; p++) begin
			gen_base[GAS]  = $urandom_range(200, 3900);
			gen_base[TEMP] = $urandom_range(200, 3900);
			if (p == 0) begin
				set_config(4095, 4095, 4095, 4095, 0, 1'b0);
			end else if (p == 1) begin
				set_config(0, 0, 0, 0, 255, 1'b0);
			end else begin
				for (k = 0; k < 2; k++)
					lim[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) :
					                                        $urandom_range(0, 120);
				set_config(lim[GAS], lim[TEMP],
					clamp12(gen_base[GAS] + int'($urandom_range(0, 120)) - 60),
					clamp12(gen_base[TEMP] + int'($urandom_range(0, 120)) - 60),
					$urandom_range(60, 100), $urandom_range(0, 1));
			end
			burst_mode = (p == 3 || p == 6);
			queue_vitals(PHASE_BEATS);
			// stall the receiver while the sender keeps offering
			if (p == 3) begin
				fork
					begin
						sink_hold = 1'b1;
						repeat (150) @(posedge clk);
						sink_hold = 1'b0;
					end
				join_none
			end
			drain_pipeline();
		end
		repeat (10) @(posedge clk);

		$display("ran %0d beats over %0d register settings: %0d block averages, %0d spikes",
			beats_in, settings_used, blocks_done, spikes_cut);
		$display("replaced, %0d zero samples; status ok %0d, alert %0d, disconnected %0d",
			zeros_skipped, status_seen[0], status_seen[1], status_seen[2]);
		if (fail_count == 0)
			$display("tb_vital_sign_spike_filter_alarm OK");
		else
			$display("tb_vital_sign_spike_filter_alarm NOT OK");
		$finish;
	end

endmodule
